// ===== hdl/ddd_pkg.sv =====
// shared types, constants and calendar tables for the date difference unit
// no dependencies

package ddd_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned COUNT_W = 23;
    localparam int unsigned SER_W   = 24;
    localparam int unsigned QY_W    = 8;

    // floor(y / 100) as (y * RECIP_100) >> RECIP_SHIFT, exact for 14-bit y
    localparam logic [26:0] RECIP_100   = 27'd5243;
    localparam int unsigned RECIP_SHIFT = 19;

    localparam logic [SER_W-1:0] COUNT_LIMIT = 24'd3652500;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    typedef struct packed {
        logic load;
        logic mul;
        logic ser;
        logic sel_b;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic out_hold;
    } t_stat;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL_A = 6'b000010,
        ST_SER_A = 6'b000100,
        ST_MUL_B = 6'b001000,
        ST_SER_B = 6'b010000,
        ST_FIN   = 6'b100000
    } t_state;

    // month length, zero for a month outside 1..12
    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the months before m of a common year
    function automatic logic [8:0] f_days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== hdl/date_difference_in_days_unit.sv =====
// date difference unit: signed day count between two gregorian dates
// the result word is registered in the output register after the steps mul_a, ser_a, mul_b, ser_b and fin
// a new word is accepted only in idle; fin of the four-step serial day sequencer waits while a word is held
// a finished word waits in the output register while the next word is accepted
// reset: synchronous active-low i_rst_n clears the sequencer and the output valid
// depends on ddd_pkg, ddd_ctrl, ddd_datapath

module date_difference_in_days_unit import ddd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // first_year, first_month, first_day, second_year, second_month, second_day
    input  logic [47:0] i_s_tdata,
    // include_end_day
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // day_count
    output logic [23:0] o_m_tdata,
    // date_error
    output logic        o_m_tuser
);

    t_cmd  cmd;
    t_stat stat;

    ddd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ddd_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== hdl/ddd_ctrl.sv =====
// sequencing state machine for the date difference unit
// depends on ddd_pkg

module ddd_ctrl import ddd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_SER_A;
            end
            ST_SER_A: begin
                o_cmd.ser = 1'b1;
                n_state   = ST_MUL_B;
            end
            ST_MUL_B: begin
                o_cmd.mul   = 1'b1;
                o_cmd.sel_b = 1'b1;
                n_state     = ST_SER_B;
            end
            ST_SER_B: begin
                o_cmd.ser   = 1'b1;
                o_cmd.sel_b = 1'b1;
                n_state     = ST_FIN;
            end
            ST_FIN: begin
                if (!i_stat.out_hold) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_MUL_A)
        else $error("load did not start the sequence");

    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> !i_stat.out_hold)
        else $error("result written over a held word");

    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |=> o_s_tready)
        else $error("not ready after finishing");

endmodule

// ===== hdl/ddd_datapath.sv =====
// datapath: serial day numbers of both dates, difference, output register
// depends on ddd_pkg

module ddd_datapath import ddd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [47:0]        i_s_tdata,
    input  logic               i_s_tuser,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [23:0]        o_m_tdata,
    output logic               o_m_tuser
);

    t_date              r_date_a;
    t_date              r_date_b;
    logic               r_inc;
    logic [QY_W-1:0]    r_qy;
    logic [SER_W-1:0]   r_ser_a;
    logic [SER_W-1:0]   r_ser_b;
    logic               r_bad_a;
    logic               r_bad_b;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_err;

    t_date              cur;
    logic [26:0]        prod;
    logic [YEAR_W-1:0]  rem;
    logic               rem_nz;
    logic               leap;
    logic [8:0]         qp;
    logic [14:0]        p;
    logic [SER_W-1:0]   n_ser;
    logic [DAY_W-1:0]   len;
    logic               n_bad;
    logic               neg;
    logic [SER_W-1:0]   diff;
    logic [SER_W-1:0]   mag;
    logic [SER_W-1:0]   mag_sat;
    logic [COUNT_W-1:0] n_count;

    assign cur = i_cmd.sel_b ? r_date_b : r_date_a;

    // year / 100 by reciprocal
    assign prod = {13'd0, cur.year} * RECIP_100;

    assign rem    = cur.year - ({6'd0, r_qy} * 14'd100);
    assign rem_nz = (rem != '0);
    assign leap   = (cur.year[1:0] == 2'b00) && (rem_nz || (r_qy[1:0] == 2'b00));
    // floor((year + 399) / 100)
    assign qp     = {1'b0, r_qy} + 9'd3 + {8'd0, rem_nz};
    assign p      = {1'b0, cur.year} + 15'd399;

    assign n_ser = (SER_W'(p) * 24'd365) + SER_W'(p >> 2) - SER_W'(qp) + SER_W'(qp >> 2)
                 + SER_W'(f_days_before(cur.month))
                 + SER_W'(leap && (cur.month > 4'd2))
                 + SER_W'(cur.day);

    assign len   = f_month_len(cur.month, leap);
    assign n_bad = (len == '0) || (cur.day == '0) || (cur.day > len);

    assign neg     = !(r_ser_a < r_ser_b);
    assign diff    = neg ? (r_ser_a - r_ser_b) : (r_ser_b - r_ser_a);
    assign mag     = diff + SER_W'(r_inc);
    assign mag_sat = (mag > COUNT_LIMIT) ? COUNT_LIMIT : mag;
    assign n_count = neg ? (23'd0 - mag_sat[COUNT_W-1:0]) : mag_sat[COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_date_a.year  <= i_s_tdata[13:0];
            r_date_a.month <= i_s_tdata[17:14];
            r_date_a.day   <= i_s_tdata[22:18];
            r_date_b.year  <= i_s_tdata[36:23];
            r_date_b.month <= i_s_tdata[40:37];
            r_date_b.day   <= i_s_tdata[45:41];
            r_inc          <= i_s_tuser;
        end
        if (i_cmd.mul) begin
            r_qy <= prod[RECIP_SHIFT +: QY_W];
        end
        if (i_cmd.ser && !i_cmd.sel_b) begin
            r_ser_a <= n_ser;
            r_bad_a <= n_bad;
        end
        if (i_cmd.ser && i_cmd.sel_b) begin
            r_ser_b <= n_ser;
            r_bad_b <= n_bad;
        end
        if (i_cmd.fin) begin
            r_out_err   <= r_bad_a || r_bad_b;
            r_out_count <= (r_bad_a || r_bad_b) ? '0 : n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_hold = r_out_valid && !i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = {1'b0, r_out_count};
    assign o_m_tuser       = r_out_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("error word carries a nonzero count");

    a_fin_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> o_m_tvalid)
        else $error("finished word not presented");

endmodule

// ===== tb/tb_top.sv =====
// testbench for date_difference_in_days_unit: directed and random date pairs,
// each day count and error flag checked against a serial-day calculation
// depends on ddd_pkg and date_difference_in_days_unit

module tb_top;
    import ddd_pkg::*;

    localparam int unsigned MAX_YEAR  = 9999;
    localparam int unsigned SPAN_CAP  = 3652500;
    localparam int unsigned CYCLE_CAP = 400000;
    localparam int unsigned HOLD_LEN  = 300;

    typedef enum int {
        PH_STEADY,
        PH_SEND_GAPS,
        PH_RECV_STALL,
        PH_BOTH_GAPS
    } t_idle_phase;

    typedef struct {
        logic [YEAR_W-1:0]  y1;
        logic [MONTH_W-1:0] m1;
        logic [DAY_W-1:0]   d1;
        logic [YEAR_W-1:0]  y2;
        logic [MONTH_W-1:0] m2;
        logic [DAY_W-1:0]   d2;
        logic               inc;
    } t_date_pair;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               err;
    } t_day_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;

    date_difference_in_days_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    t_date_pair  pending_pairs[$];
    t_day_result expected_spans[$];
    t_date_pair  cur_pair;
    t_idle_phase idle_phase;
    logic        offering;
    logic        offer_done;
    logic        hold_arm;
    int unsigned hold_left;
    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned words_in;
    int unsigned words_out;
    int unsigned error_words;
    int unsigned negative_words;
    int unsigned capped_words;

    // predictor state: later date of the last pair (first date if invalid), last magnitude and sign
    logic [YEAR_W-1:0]  walk_year;
    logic [MONTH_W-1:0] walk_month;
    logic [DAY_W-1:0]   walk_day;
    logic [COUNT_W-1:0] span_tally;
    logic               span_negated;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit is_leap(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_ok(int unsigned y, int unsigned m, int unsigned d);
        return (days_in_month(m, y) != 0) && (d >= 1) && (d <= days_in_month(m, y));
    endfunction

    // day number of a valid date, shifted by 400 years so year 0 works
    function automatic int unsigned day_serial(int unsigned y, int unsigned m,
                                               int unsigned d);
        int unsigned p;
        int unsigned s;
        p = y + 399;
        s = 365 * p + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < m; k++)
            s += days_in_month(k, y);
        return s + d;
    endfunction

    function automatic t_day_result day_span(t_date_pair dp);
        t_day_result r;
        int unsigned mag;
        r.count = '0;
        r.err   = 1'b1;
        if (!date_ok(dp.y1, dp.m1, dp.d1) || !date_ok(dp.y2, dp.m2, dp.d2)) begin
            walk_year    = dp.y1;
            walk_month   = dp.m1;
            walk_day     = dp.d1;
            span_tally   = '0;
            span_negated = 1'b0;
            return r;
        end
        if ({dp.y1, dp.m1, dp.d1} < {dp.y2, dp.m2, dp.d2}) begin
            mag = day_serial(dp.y2, dp.m2, dp.d2) - day_serial(dp.y1, dp.m1, dp.d1);
            span_negated = 1'b0;
            {walk_year, walk_month, walk_day} = {dp.y2, dp.m2, dp.d2};
        end else begin
            mag = day_serial(dp.y1, dp.m1, dp.d1) - day_serial(dp.y2, dp.m2, dp.d2);
            span_negated = 1'b1;
            {walk_year, walk_month, walk_day} = {dp.y1, dp.m1, dp.d1};
        end
        if (dp.inc)
            mag += 1;
        if (mag > SPAN_CAP)
            mag = SPAN_CAP;
        span_tally = mag[COUNT_W-1:0];
        r.count = span_negated ? -span_tally : span_tally;
        r.err   = 1'b0;
        return r;
    endfunction

    function automatic void pick_date(output logic [YEAR_W-1:0] y,
                                      output logic [MONTH_W-1:0] m,
                                      output logic [DAY_W-1:0] d);
        if ($urandom_range(99) < 8)
            y = YEAR_W'($urandom_range(16383));
        else
            y = YEAR_W'($urandom_range(MAX_YEAR, 1));
        m = MONTH_W'($urandom_range(12, 1));
        d = DAY_W'($urandom_range(days_in_month(m, y), 1));
    endfunction

    function automatic t_date_pair random_pair();
        t_date_pair dp;
        int unsigned kind;
        kind = $urandom_range(99);
        pick_date(dp.y1, dp.m1, dp.d1);
        pick_date(dp.y2, dp.m2, dp.d2);
        if (kind < 20) begin
            // same year, random month and day
            dp.y2 = dp.y1;
            dp.m2 = MONTH_W'($urandom_range(12, 1));
            dp.d2 = DAY_W'($urandom_range(days_in_month(dp.m2, dp.y2), 1));
        end else if (kind < 30) begin
            {dp.y2, dp.m2, dp.d2} = {dp.y1, dp.m1, dp.d1};
        end else if (kind < 45) begin
            // raw fields of one date, which may be invalid
            if ($urandom_range(1)) begin
                dp.m1 = MONTH_W'($urandom);
                dp.d1 = DAY_W'($urandom);
            end else begin
                dp.m2 = MONTH_W'($urandom);
                dp.d2 = DAY_W'($urandom);
            end
        end
        dp.inc = 1'($urandom_range(1));
        return dp;
    endfunction

    task automatic push_pair(int unsigned y1, int unsigned m1, int unsigned d1,
                             int unsigned y2, int unsigned m2, int unsigned d2,
                             bit inc);
        t_date_pair dp;
        dp.y1 = YEAR_W'(y1); dp.m1 = MONTH_W'(m1); dp.d1 = DAY_W'(d1);
        dp.y2 = YEAR_W'(y2); dp.m2 = MONTH_W'(m2); dp.d2 = DAY_W'(d2);
        dp.inc = inc;
        pending_pairs.push_back(dp);
    endtask

    task automatic drain();
        while (pending_pairs.size() != 0 || offering || expected_spans.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(t_idle_phase ph, int unsigned n);
        idle_phase = ph;
        repeat (n) pending_pairs.push_back(random_pair());
        drain();
    endtask

    // sender: a new word goes out at the falling edge after the last was taken, unless an idle gap is drawn
    always @(negedge i_clk) begin
        bit idle_now;
        case (idle_phase)
            PH_SEND_GAPS: idle_now = ($urandom_range(99) < 64);
            PH_BOTH_GAPS: idle_now = ($urandom_range(99) < 7);
            default:      idle_now = 1'b0;
        endcase
        if (!offering || offer_done) begin
            offer_done = 1'b0;
            if (pending_pairs.size() != 0 && !idle_now) begin
                cur_pair = pending_pairs.pop_front();
                i_s_tdata <= {2'b00, cur_pair.d2, cur_pair.m2, cur_pair.y2,
                              cur_pair.d1, cur_pair.m1, cur_pair.y1};
                i_s_tuser <= cur_pair.inc;
                i_s_tvalid <= 1'b1;
                offering = 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
                offering = 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(negedge i_clk) begin
        if (hold_arm)
            hold_left <= HOLD_LEN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(negedge i_clk) begin
        bit stall_now;
        case (idle_phase)
            PH_RECV_STALL: stall_now = ($urandom_range(99) < 64);
            PH_BOTH_GAPS:  stall_now = ($urandom_range(99) < 7);
            default:       stall_now = 1'b0;
        endcase
        i_m_tready <= (hold_left == 0) && !stall_now;
    end

    // input acceptance, output checking and the cycle limit
    always @(posedge i_clk) begin
        t_day_result want;
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("TEST FAILED");
            $finish;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_spans.push_back(day_span(cur_pair));
                offer_done = 1'b1;
                words_in++;
            end
            if (o_m_tvalid && i_m_tready) begin
                words_out++;
                if (expected_spans.size() == 0) begin
                    fail_count++;
                    $display("%0t unexpected word: got count %0d error %0b", $time,
                             $signed(o_m_tdata[COUNT_W-1:0]), o_m_tuser);
                end else begin
                    want = expected_spans.pop_front();
                    if (want.err) error_words++;
                    if (!want.err && want.count[COUNT_W-1]) negative_words++;
                    if (want.count == COUNT_W'(SPAN_CAP) ||
                        want.count == (COUNT_W'(0) - COUNT_W'(SPAN_CAP)))
                        capped_words++;
                    if (o_m_tdata[COUNT_W-1:0] !== want.count) begin
                        fail_count++;
                        $display("%0t day_count mismatch: expected %0d, got %0d", $time,
                                 $signed(want.count), $signed(o_m_tdata[COUNT_W-1:0]));
                    end
                    if (o_m_tuser !== want.err) begin
                        fail_count++;
                        $display("%0t date_error mismatch: expected %0b, got %0b", $time,
                                 want.err, o_m_tuser);
                    end
                end
            end
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = 1'b0;
        i_m_tready     = 1'b0;
        hold_arm       = 1'b0;
        hold_left      = 0;
        offering       = 1'b0;
        offer_done     = 1'b0;
        idle_phase     = PH_STEADY;
        cycle_count    = 0;
        fail_count     = 0;
        words_in       = 0;
        words_out      = 0;
        error_words    = 0;
        negative_words = 0;
        capped_words   = 0;
        walk_year      = '0;
        walk_month     = '0;
        walk_day       = '0;
        span_tally     = '0;
        span_negated   = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // equal dates, both orders, full range, leap rules, rollovers, invalid fields
        push_pair(2024, 5, 17, 2024, 5, 17, 0);
        push_pair(2024, 5, 17, 2024, 5, 17, 1);
        push_pair(2020, 1, 1, 2021, 3, 15, 0);
        push_pair(2021, 3, 15, 2020, 1, 1, 1);
        push_pair(1, 1, 1, MAX_YEAR, 12, 31, 1);
        push_pair(MAX_YEAR, 12, 31, 1, 1, 1, 0);
        push_pair(0, 1, 1, 16383, 12, 31, 1);
        push_pair(16383, 12, 31, 0, 2, 29, 0);
        push_pair(2000, 2, 29, 2000, 3, 1, 0);
        push_pair(1900, 2, 29, 1900, 3, 1, 0);
        push_pair(2004, 2, 28, 2004, 2, 29, 1);
        push_pair(2001, 2, 29, 2001, 3, 1, 0);
        push_pair(1999, 12, 31, 2000, 1, 1, 0);
        push_pair(2023, 1, 31, 2023, 2, 1, 0);
        push_pair(2023, 0, 10, 2023, 5, 5, 0);
        push_pair(2023, 13, 10, 2023, 5, 5, 1);
        push_pair(2023, 15, 31, 2023, 5, 5, 0);
        push_pair(2023, 4, 0, 2023, 5, 5, 0);
        push_pair(2023, 4, 31, 2023, 5, 5, 0);
        push_pair(2023, 5, 5, 2023, 6, 31, 1);
        push_pair(2023, 5, 5, 6144, 15, 0, 0);
        push_pair(6144, 12, 31, 7000, 12, 31, 1);
        drain();

        run_phase(PH_STEADY, 16);
        run_phase(PH_SEND_GAPS, 16);
        run_phase(PH_RECV_STALL, 16);
        run_phase(PH_BOTH_GAPS, 16);

        // receiver holds off while words keep coming
        idle_phase = PH_STEADY;
        repeat (12) pending_pairs.push_back(random_pair());
        @(posedge i_clk);
        hold_arm <= 1'b1;
        @(posedge i_clk);
        hold_arm <= 1'b0;
        drain();

        repeat (20) @(posedge i_clk);
        if (expected_spans.size() != 0) begin
            fail_count++;
            $display("%0t %0d expected words never arrived", $time, expected_spans.size());
        end
        $display("covered %0d date pairs, %0d results: %0d invalid, %0d negative, %0d capped",
                 words_in, words_out, error_words, negative_words, capped_words);
        $display("idle phases: none, sender gaps, receiver stalls, both, long receiver hold");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
